@@ src/wfhp_pkg.sv @@
// shared types, codes and constants of the websocket frame header parser
package wfhp_pkg;

   // queue depths
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   // result status codes
   localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
   localparam logic [1:0] STATUS_COMPLETE   = 2'd1;
   localparam logic [1:0] STATUS_ERROR      = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_RESERVED   = 3'd1;
   localparam logic [2:0] ERR_CTRL_FRAG  = 3'd2;
   localparam logic [2:0] ERR_CTRL_LARGE = 3'd3;
   localparam logic [2:0] ERR_FAILED     = 3'd4;

   // transaction kinds
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // header field constants
   localparam logic [6:0] CTRL_LEN_MAX = 7'd125;
   localparam logic [6:0] LEN7_EXT16   = 7'd126;
   localparam logic [6:0] LEN7_EXT64   = 7'd127;
   localparam logic [3:0] EXT16_BYTES  = 4'd2;
   localparam logic [3:0] EXT64_BYTES  = 4'd8;
   localparam logic [3:0] KEY_BYTES    = 4'd4;

   // input transaction
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  error_code;
      logic        fin_flag;
      logic [3:0]  frame_opcode;
      logic        masked;
      logic [63:0] payload_size;
      logic [31:0] mask_key;
   } rsp_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic       restart;
      logic       top_bit;
      logic       rsv_set;
      logic [3:0] opcode;
      logic [6:0] len7;
      logic       len_over_max;
      logic       len_ext16;
      logic       len_ext64;
      logic [7:0] data_byte;
   } cmd_type;

endpackage

@@ src/wfhp_fifo.sv @@
// small register queue with fall-through read, depth at least two
module wfhp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = wfhp_pkg::CMD_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   // handshake status
   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/wfhp_front.sv @@
// front end: classifies each incoming transaction before it is queued
module wfhp_front (
   input  wfhp_pkg::req_type req,
   output wfhp_pkg::cmd_type cmd
);

   logic [6:0] len7;

   assign len7 = req.data_byte[6:0];

   // decode the byte for both header byte positions
   always_comb begin
      cmd.restart      = (req.kind == wfhp_pkg::KIND_RESTART);
      cmd.top_bit      = req.data_byte[7];
      cmd.rsv_set      = (req.data_byte[6:4] != 3'b000);
      cmd.opcode       = req.data_byte[3:0];
      cmd.len7         = len7;
      cmd.len_over_max = (len7 > wfhp_pkg::CTRL_LEN_MAX);
      cmd.len_ext16    = (len7 == wfhp_pkg::LEN7_EXT16);
      cmd.len_ext64    = (len7 == wfhp_pkg::LEN7_EXT64);
      cmd.data_byte    = req.data_byte;
   end

endmodule

@@ src/wfhp_back.sv @@
// back end: header parsing state machine, one classified byte per cycle while one waits and the result queue has room
module wfhp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  wfhp_pkg::cmd_type cmd,
   output logic              cmd_take,
   input  logic              rsp_full,
   output logic              rsp_push,
   output wfhp_pkg::rsp_type rsp
);

   typedef enum logic [2:0] {
      PH_BYTE0 = 3'd0,
      PH_BYTE1 = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_KEY   = 3'd4,
      PH_DONE  = 3'd5,
      PH_FAIL  = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  count_ff, count_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [63:0] length_ff, length_in;
   logic [31:0] key_ff, key_in;
   logic [3:0]  count_next;
   logic [1:0]  status;
   logic [2:0]  error_code;

   // take a transaction whenever one waits and the result queue has room
   assign cmd_take   = cmd_valid && !rsp_full;
   assign rsp_push   = cmd_take;
   assign count_next = count_ff + 4'd1;

   // next state
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      fin_in     = fin_ff;
      opcode_in  = opcode_ff;
      mask_in    = mask_ff;
      length_in  = length_ff;
      key_in     = key_ff;
      status     = wfhp_pkg::STATUS_INCOMPLETE;
      error_code = wfhp_pkg::ERR_NONE;
      if (cmd_take) begin
         if (cmd.restart) begin
            phase_in  = PH_BYTE0;
            count_in  = '0;
            fin_in    = 1'b0;
            opcode_in = '0;
            mask_in   = 1'b0;
            length_in = '0;
            key_in    = '0;
         end else begin
            case (phase_ff)
               PH_BYTE0: begin
                  fin_in    = cmd.top_bit;
                  opcode_in = cmd.opcode;
                  mask_in   = 1'b0;
                  length_in = '0;
                  key_in    = '0;
                  count_in  = '0;
                  if (cmd.rsv_set) begin
                     phase_in   = PH_FAIL;
                     status     = wfhp_pkg::STATUS_ERROR;
                     error_code = wfhp_pkg::ERR_RESERVED;
                  end else begin
                     phase_in = PH_BYTE1;
                  end
               end
               PH_BYTE1: begin
                  mask_in = cmd.top_bit;
                  if (opcode_ff[3] && !fin_ff) begin
                     phase_in   = PH_FAIL;
                     status     = wfhp_pkg::STATUS_ERROR;
                     error_code = wfhp_pkg::ERR_CTRL_FRAG;
                  end else if (opcode_ff[3] && cmd.len_over_max) begin
                     phase_in   = PH_FAIL;
                     status     = wfhp_pkg::STATUS_ERROR;
                     error_code = wfhp_pkg::ERR_CTRL_LARGE;
                  end else begin
                     count_in = '0;
                     if (cmd.len_ext16) begin
                        length_in = '0;
                        phase_in  = PH_EXT16;
                     end else if (cmd.len_ext64) begin
                        length_in = '0;
                        phase_in  = PH_EXT64;
                     end else begin
                        length_in = {57'd0, cmd.len7};
                        if (cmd.top_bit) begin
                           key_in   = '0;
                           phase_in = PH_KEY;
                        end else begin
                           phase_in = PH_DONE;
                           status   = wfhp_pkg::STATUS_COMPLETE;
                        end
                     end
                  end
               end
               PH_EXT16, PH_EXT64: begin
                  length_in = {length_ff[55:0], cmd.data_byte};
                  count_in  = count_next;
                  if (count_next >= ((phase_ff == PH_EXT16) ? wfhp_pkg::EXT16_BYTES
                                                            : wfhp_pkg::EXT64_BYTES)) begin
                     count_in = '0;
                     if (mask_ff) begin
                        key_in   = '0;
                        phase_in = PH_KEY;
                     end else begin
                        phase_in = PH_DONE;
                        status   = wfhp_pkg::STATUS_COMPLETE;
                     end
                  end
               end
               PH_KEY: begin
                  key_in   = {key_ff[23:0], cmd.data_byte};
                  count_in = count_next;
                  if (count_next >= wfhp_pkg::KEY_BYTES) begin
                     count_in = '0;
                     phase_in = PH_DONE;
                     status   = wfhp_pkg::STATUS_COMPLETE;
                  end
               end
               PH_DONE: begin
                  status = wfhp_pkg::STATUS_COMPLETE;
               end
               default: begin
                  // failed phase and the unused phase code
                  phase_in   = PH_FAIL;
                  status     = wfhp_pkg::STATUS_ERROR;
                  error_code = wfhp_pkg::ERR_FAILED;
               end
            endcase
         end
      end
   end

   // result: decoded header only when complete
   always_comb begin
      rsp                = '0;
      rsp.status         = status;
      rsp.error_code     = error_code;
      if (status == wfhp_pkg::STATUS_COMPLETE) begin
         rsp.fin_flag     = fin_in;
         rsp.frame_opcode = opcode_in;
         rsp.masked       = mask_in;
         rsp.payload_size = length_in;
         rsp.mask_key     = key_in;
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BYTE0;
         count_ff  <= '0;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         length_ff <= '0;
         key_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         length_ff <= length_in;
         key_ff    <= key_in;
      end
   end

endmodule

@@ src/websocket_frame_header_parser.sv @@
// Byte-serial WebSocket frame header parser. One transaction (a header byte or a restart)
// is taken per clock unless a queue stalls and yields exactly one result transaction:
// header incomplete, header complete with the decoded fin, opcode, mask flag, payload
// length and masking key, or an error. The sustained rate is one transaction per cycle
// when nothing stalls, set by the back end parser state update; an accepted input is
// registered in the command queue and its result in the result queue. A short command
// queue between the classifying front end and the parser, and a result queue after it,
// let either side stall on its own. After an error every header byte reports the failed
// state until a restart; after a complete header further bytes repeat the complete
// result. No extended-length encoding checks are made.
module websocket_frame_header_parser #(
   parameter int CMD_DEPTH = wfhp_pkg::CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH = wfhp_pkg::RSP_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  wfhp_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output wfhp_pkg::rsp_type rsp_data
);

   localparam int CMD_W = $bits(wfhp_pkg::cmd_type);
   localparam int RSP_W = $bits(wfhp_pkg::rsp_type);

   wfhp_pkg::cmd_type cmd_in, cmd_out;
   wfhp_pkg::rsp_type rsp_in;
   logic [CMD_W-1:0]  cmd_bits;
   logic [RSP_W-1:0]  rsp_bits;
   logic              cmd_empty, cmd_take;
   logic              rsp_full, rsp_push;

   // classify incoming transactions
   wfhp_front u_front (
      .req (req_data),
      .cmd (cmd_in)
   );

   // queue between front and back
   wfhp_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (cmd_in),
      .full      (full),
      .pop       (cmd_take),
      .pop_data  (cmd_bits),
      .empty     (cmd_empty)
   );

   assign cmd_out = wfhp_pkg::cmd_type'(cmd_bits);

   // header parser
   wfhp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd       (cmd_out),
      .cmd_take  (cmd_take),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in)
   );

   // result queue
   wfhp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty)
   );

   assign rsp_data = wfhp_pkg::rsp_type'(rsp_bits);

endmodule

@@ dv/tb_websocket_frame_header_parser.sv @@
// testbench for the websocket frame header parser: directed table, random frames, scoreboard
module tb_websocket_frame_header_parser;
   import wfhp_pkg::*;

   localparam int RANDOM_ITEMS     = 1625;
   localparam int TAIL_ITEMS       = 200;
   localparam int LONG_HOLD_AT     = 700;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 16;
   localparam int DIRECTED_COUNT   = 27;

   // parser phases of the predictor
   typedef enum logic [2:0] {
      PH_FIRST, PH_SECOND, PH_EXT16, PH_EXT64, PH_KEY, PH_DONE, PH_FAILED
   } parse_phase_type;

   // one stimulus row: the transaction and, where typed in, its expected result
   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type want;
   } stim_type;

   localparam rsp_type UNTYPED      = '0;
   localparam rsp_type RSP_RESTART  = '{STATUS_INCOMPLETE, ERR_NONE, 1'b0, 4'h0, 1'b0, 64'h0, 32'h0};
   localparam rsp_type RSP_RESERVED = '{STATUS_ERROR, ERR_RESERVED, 1'b0, 4'h0, 1'b0, 64'h0, 32'h0};
   localparam rsp_type RSP_FAILED   = '{STATUS_ERROR, ERR_FAILED, 1'b0, 4'h0, 1'b0, 64'h0, 32'h0};
   localparam rsp_type RSP_FRAG     = '{STATUS_ERROR, ERR_CTRL_FRAG, 1'b0, 4'h0, 1'b0, 64'h0, 32'h0};
   localparam rsp_type RSP_LARGE    = '{STATUS_ERROR, ERR_CTRL_LARGE, 1'b0, 4'h0, 1'b0, 64'h0, 32'h0};
   localparam rsp_type RSP_LONG_DONE =
      '{STATUS_COMPLETE, ERR_NONE, 1'b0, 4'h1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0};
   localparam rsp_type RSP_KEY_DONE =
      '{STATUS_COMPLETE, ERR_NONE, 1'b1, 4'h9, 1'b1, 64'd125, 32'hDEAD_BEEF};

   // directed table: reset state, reserved bits, failed state, control checks,
   // all-ones 64-bit length, complete repeat, masked ping with key
   localparam stim_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{KIND_BYTE, 8'h70}, 1'b1, RSP_RESERVED},
      '{'{KIND_BYTE, 8'h55}, 1'b1, RSP_FAILED},
      '{'{KIND_RESTART, 8'h00}, 1'b1, RSP_RESTART},
      '{'{KIND_BYTE, 8'h08}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'h00}, 1'b1, RSP_FRAG},
      '{'{KIND_RESTART, 8'hFF}, 1'b1, RSP_RESTART},
      '{'{KIND_BYTE, 8'h89}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFE}, 1'b1, RSP_LARGE},
      '{'{KIND_RESTART, 8'h00}, 1'b1, RSP_RESTART},
      '{'{KIND_BYTE, 8'h01}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'h7F}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFF}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFF}, 1'b1, RSP_LONG_DONE},
      '{'{KIND_BYTE, 8'h00}, 1'b1, RSP_LONG_DONE},
      '{'{KIND_RESTART, 8'h5A}, 1'b1, RSP_RESTART},
      '{'{KIND_BYTE, 8'h89}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hFD}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hDE}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hAD}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hBE}, 1'b0, UNTYPED},
      '{'{KIND_BYTE, 8'hEF}, 1'b1, RSP_KEY_DONE}
   };

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   // predictor state
   parse_phase_type parser_phase;
   logic [3:0]      taken_bytes;
   logic            saw_fin;
   logic [3:0]      saw_opcode;
   logic            saw_mask;
   logic [63:0]     length_so_far;
   logic [31:0]     key_so_far;

   stim_type byte_stream [$];
   rsp_type  header_results [$];
   int       accepted_count;
   int       field_mismatches;
   int       complete_seen;
   int       errors_seen;
   int       restarts_sent;
   bit       tail_quiet;

   websocket_frame_header_parser DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // clear the parser as at reset or on a restart
   function automatic void clear_parser();
      parser_phase  = PH_FIRST;
      taken_bytes   = '0;
      saw_fin       = 1'b0;
      saw_opcode    = '0;
      saw_mask      = 1'b0;
      length_so_far = '0;
      key_so_far    = '0;
   endfunction

   // length known: a key follows when masked, otherwise the header is complete
   function automatic logic [1:0] finish_length();
      taken_bytes = '0;
      if (saw_mask) begin
         key_so_far   = '0;
         parser_phase = PH_KEY;
         return STATUS_INCOMPLETE;
      end
      parser_phase = PH_DONE;
      return STATUS_COMPLETE;
   endfunction

   // expected result of one transaction, advancing the predicted parser state
   function automatic rsp_type parse_header_byte(input req_type item);
      rsp_type    res;
      logic [7:0] b;
      logic [6:0] len7;
      logic [1:0] st;
      logic [2:0] err;
      b    = item.data_byte;
      len7 = b[6:0];
      st   = STATUS_INCOMPLETE;
      err  = ERR_NONE;
      if (item.kind == KIND_RESTART) begin
         clear_parser();
      end else begin
         case (parser_phase)
            PH_FIRST: begin
               saw_fin       = b[7];
               saw_opcode    = b[3:0];
               saw_mask      = 1'b0;
               length_so_far = '0;
               key_so_far    = '0;
               taken_bytes   = '0;
               if (|b[6:4]) begin
                  parser_phase = PH_FAILED;
                  st           = STATUS_ERROR;
                  err          = ERR_RESERVED;
               end else begin
                  parser_phase = PH_SECOND;
               end
            end
            PH_SECOND: begin
               saw_mask = b[7];
               // control frames: fin first, then the length limit
               if (saw_opcode[3] && !saw_fin) begin
                  parser_phase = PH_FAILED;
                  st           = STATUS_ERROR;
                  err          = ERR_CTRL_FRAG;
               end else if (saw_opcode[3] && len7 > CTRL_LEN_MAX) begin
                  parser_phase = PH_FAILED;
                  st           = STATUS_ERROR;
                  err          = ERR_CTRL_LARGE;
               end else begin
                  taken_bytes = '0;
                  if (len7 == LEN7_EXT16) begin
                     length_so_far = '0;
                     parser_phase  = PH_EXT16;
                  end else if (len7 == LEN7_EXT64) begin
                     length_so_far = '0;
                     parser_phase  = PH_EXT64;
                  end else begin
                     length_so_far = 64'(len7);
                     st            = finish_length();
                  end
               end
            end
            PH_EXT16, PH_EXT64: begin
               length_so_far = {length_so_far[55:0], b};
               taken_bytes   = taken_bytes + 4'd1;
               if (taken_bytes >= (parser_phase == PH_EXT16 ? EXT16_BYTES : EXT64_BYTES)) begin
                  st = finish_length();
               end
            end
            PH_KEY: begin
               key_so_far  = {key_so_far[23:0], b};
               taken_bytes = taken_bytes + 4'd1;
               if (taken_bytes >= KEY_BYTES) begin
                  taken_bytes  = '0;
                  parser_phase = PH_DONE;
                  st           = STATUS_COMPLETE;
               end
            end
            PH_DONE: begin
               st = STATUS_COMPLETE;
            end
            default: begin
               parser_phase = PH_FAILED;
               st           = STATUS_ERROR;
               err          = ERR_FAILED;
            end
         endcase
      end
      res            = '0;
      res.status     = st;
      res.error_code = err;
      if (st == STATUS_COMPLETE) begin
         res.fin_flag     = saw_fin;
         res.frame_opcode = saw_opcode;
         res.masked       = saw_mask;
         res.payload_size = length_so_far;
         res.mask_key     = key_so_far;
      end
      return res;
   endfunction

   function automatic void add_item(input logic kind, input logic [7:0] data_byte);
      stim_type row;
      row           = '0;
      row.item.kind = kind;
      row.item.data_byte = data_byte;
      byte_stream.push_back(row);
   endfunction

   // one random frame: mostly well-formed headers, some noise and cut-off frames
   function automatic void append_random_frame();
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] body [$];
      int         pick;
      int         extra;
      int         total;
      pick = int'($urandom_range(0, 99));
      if (pick < 6) begin
         repeat ($urandom_range(1, 4)) begin
            add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
         return;
      end
      add_item(KIND_RESTART, 8'($urandom_range(0, 255)));
      first_byte = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 19) != 0) first_byte[6:4] = 3'b000;
      if (first_byte[3] && $urandom_range(0, 9) != 0) first_byte[7] = 1'b1;
      second_byte = 8'($urandom_range(0, 255));
      pick = int'($urandom_range(0, 3));
      if (pick == 2) second_byte[6:0] = LEN7_EXT16;
      else if (pick == 3) second_byte[6:0] = LEN7_EXT64;
      // control frames mostly keep within the length limit
      if (first_byte[3] && second_byte[6:0] > CTRL_LEN_MAX && $urandom_range(0, 9) != 0) begin
         second_byte[6:0] = 7'($urandom_range(0, 125));
      end
      body.push_back(first_byte);
      body.push_back(second_byte);
      extra = (second_byte[6:0] == LEN7_EXT16) ? 2 : (second_byte[6:0] == LEN7_EXT64) ? 8 : 0;
      if (second_byte[7]) extra += 4;
      // up to one byte past the header lands in the complete phase
      extra += int'($urandom_range(0, 1));
      repeat (extra) body.push_back(8'($urandom_range(0, 255)));
      total = body.size();
      if ($urandom_range(0, 9) == 0) total = int'($urandom_range(1, body.size()));
      for (int n = 0; n < total; n++) add_item(KIND_BYTE, body[n]);
   endfunction

   // sender: directed table then random frames, with gaps and two drained pauses
   initial begin : sender
      rsp_type expected;
      int      pause_mid;
      push           <= 1'b0;
      req_data       <= '0;
      accepted_count = 0;
      restarts_sent  = 0;
      tail_quiet     = 1'b0;
      clear_parser();
      foreach (DIRECTED_ROWS[i]) byte_stream.push_back(DIRECTED_ROWS[i]);
      while (byte_stream.size() < DIRECTED_COUNT + RANDOM_ITEMS) append_random_frame();
      pause_mid = DIRECTED_COUNT + (byte_stream.size() - DIRECTED_COUNT) / 2;
      do @(posedge clock); while (reset);
      for (int idx = 0; idx < byte_stream.size(); idx++) begin
         tail_quiet = (idx >= byte_stream.size() - TAIL_ITEMS);
         if (idx == DIRECTED_COUNT || idx == pause_mid) begin
            // hold off until every expected result has come back
            push <= 1'b0;
            do @(posedge clock); while (header_results.size() != 0);
         end else if (!tail_quiet && $urandom_range(0, 9) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         push     <= 1'b1;
         req_data <= byte_stream[idx].item;
         do @(posedge clock); while (full);
         expected = parse_header_byte(byte_stream[idx].item);
         if (byte_stream[idx].typed) expected = byte_stream[idx].want;
         header_results.push_back(expected);
         if (byte_stream[idx].item.kind == KIND_RESTART) restarts_sent++;
         accepted_count++;
      end
      push <= 1'b0;
      while (header_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d transactions with %0d restarts, one long result stall",
               accepted_count, restarts_sent);
      $display("and two drained pauses: %0d complete and %0d error results checked",
               complete_seen, errors_seen);
      if (field_mismatches == 0 && header_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         field_mismatches++;
      end
   endfunction

   // receiver: check each result transaction, stall in random bursts and once for long
   initial begin : receiver
      rsp_type want;
      int      hold;
      bit      long_hold_done;
      pop              <= 1'b0;
      hold             = 0;
      long_hold_done   = 1'b0;
      field_mismatches = 0;
      complete_seen    = 0;
      errors_seen      = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (pop && !empty) begin
            if (header_results.size() == 0) begin
               $display("%0t: unexpected result, expected none got %0h", $time, rsp_data);
               field_mismatches++;
            end else begin
               want = header_results.pop_front();
               check_field("status", 64'(want.status), 64'(rsp_data.status));
               check_field("error_code", 64'(want.error_code), 64'(rsp_data.error_code));
               check_field("fin_flag", 64'(want.fin_flag), 64'(rsp_data.fin_flag));
               check_field("frame_opcode", 64'(want.frame_opcode), 64'(rsp_data.frame_opcode));
               check_field("masked", 64'(want.masked), 64'(rsp_data.masked));
               check_field("payload_size", want.payload_size, rsp_data.payload_size);
               check_field("mask_key", 64'(want.mask_key), 64'(rsp_data.mask_key));
               if (want.status == STATUS_COMPLETE) complete_seen++;
               if (want.status == STATUS_ERROR) errors_seen++;
            end
         end
         if (!long_hold_done && accepted_count >= LONG_HOLD_AT) begin
            hold           = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else if (hold == 0 && !tail_quiet && $urandom_range(0, 9) == 0) begin
            hold = int'($urandom_range(1, 15));
         end
         if (hold > 0) begin
            pop <= 1'b0;
            hold--;
         end else begin
            pop <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // watchdog: too many cycles with no transaction on either side
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty)) quiet = 0;
         else quiet++;
      end
      $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
src/wfhp_pkg.sv
src/wfhp_fifo.sv
src/wfhp_front.sv
src/wfhp_back.sv
src/websocket_frame_header_parser.sv
dv/tb_websocket_frame_header_parser.sv
